// ----- rtl/bdmx_pkg.sv -----
// Shared types and constants for the packet and command byte demultiplexer.
`timescale 1ns / 1ps

package bdmx_pkg;

   localparam int LEN_W  = 7;
   localparam int BYTE_W = 8;
   localparam int CMD_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_RX   = 2'd0,
      CMD_POP  = 2'd1,
      CMD_READ = 2'd2,
      CMD_IDLE = 2'd3
   } cmd_type;

   localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_QUERY   = 8'h3F;
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;

   // Packet assembler status for the beat being accepted.
   typedef struct packed {
      logic             open;    // a packet is being assembled (before this beat)
      logic             done;    // this beat closed a packet
      logic             hit;     // read index falls inside the completed packet
      logic [LEN_W-1:0] length;  // completed packet length after this beat
   } pkt_stat_type;

   // Command ring status for the beat being accepted.
   typedef struct packed {
      logic popped;
      logic overwrote;
   } ring_stat_type;

   function automatic logic is_cmd_char(input logic [BYTE_W-1:0] b);
      is_cmd_char = ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) || (b == CH_QUERY);
   endfunction

endpackage

// ----- rtl/bdmx_pkt_asm.sv -----
// Packet assembler: two-bank packet memory with fill and completion tracking.
`timescale 1ns / 1ps

module bdmx_pkt_asm #(
   parameter int PACKET_MAX = 94
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  bdmx_pkg::cmd_type                   cmd,
   input  logic [bdmx_pkg::BYTE_W-1:0]         rx_byte,
   input  logic [bdmx_pkg::LEN_W-1:0]          read_index,
   output bdmx_pkg::pkt_stat_type              stat,
   output logic [bdmx_pkg::BYTE_W-1:0]         rd_data
);

   localparam int DEPTH = 2 * PACKET_MAX;
   localparam int AW    = $clog2(DEPTH);

   logic                         in_packet_ff, in_packet_in;
   logic [bdmx_pkg::LEN_W-1:0]   fill_ff, fill_in;
   logic                         bank_ff, bank_in;
   logic [bdmx_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                         done;
   logic                         wr_en;
   logic [bdmx_pkg::LEN_W-1:0]   wr_ofs;
   logic [AW-1:0]                wr_addr;
   logic [AW-1:0]                rd_addr;
   logic                         hit;
   logic                         rd_en;
   logic [bdmx_pkg::BYTE_W-1:0]  mem [DEPTH];
   logic [bdmx_pkg::BYTE_W-1:0]  rd_data_ff;

   always_comb begin
      in_packet_in = in_packet_ff;
      fill_in      = fill_ff;
      bank_in      = bank_ff;
      len_in       = len_ff;
      done         = 1'b0;
      wr_en        = 1'b0;
      wr_ofs       = fill_ff;
      if (accept && (cmd == bdmx_pkg::CMD_RX)) begin
         if (rx_byte == bdmx_pkg::CH_DOLLAR) begin
            // restart: the dollar lands at position zero
            in_packet_in = 1'b1;
            wr_en        = 1'b1;
            wr_ofs       = '0;
            fill_in      = bdmx_pkg::LEN_W'(1);
         end else if (in_packet_ff) begin
            if (fill_ff < bdmx_pkg::LEN_W'(PACKET_MAX)) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + bdmx_pkg::LEN_W'(1);
            end
            if (rx_byte == bdmx_pkg::CH_NEWLINE) begin
               bank_in      = ~bank_ff;
               len_in       = fill_in;
               in_packet_in = 1'b0;
               done         = 1'b1;
            end
         end
      end
   end

   // Fill the bank not holding the completed packet.
   assign wr_addr = bank_ff ? AW'(wr_ofs) : AW'(wr_ofs) + AW'(PACKET_MAX);
   assign rd_addr = bank_ff ? AW'(read_index) + AW'(PACKET_MAX) : AW'(read_index);
   assign hit     = (cmd == bdmx_pkg::CMD_READ) && (read_index < len_ff);
   assign rd_en   = accept && hit;

   assign stat.open   = in_packet_ff;
   assign stat.done   = done;
   assign stat.hit    = hit;
   assign stat.length = len_in;
   assign rd_data     = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         fill_ff      <= '0;
         bank_ff      <= 1'b0;
         len_ff       <= '0;
      end else begin
         in_packet_ff <= in_packet_in;
         fill_ff      <= fill_in;
         bank_ff      <= bank_in;
         len_ff       <= len_in;
      end
   end

endmodule

// ----- rtl/bdmx_cmd_ring.sv -----
// Command ring: circular store that overwrites the oldest entry when full.
`timescale 1ns / 1ps

module bdmx_cmd_ring #(
   parameter int RING_SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                pop,
   input  logic [bdmx_pkg::BYTE_W-1:0]         code_in,
   output bdmx_pkg::ring_stat_type             stat,
   output logic [$clog2(RING_SLOTS)-1:0]       count,
   output logic [bdmx_pkg::BYTE_W-1:0]         rd_data
);

   localparam int PW = $clog2(RING_SLOTS);
   localparam logic [PW-1:0] LAST = PW'(RING_SLOTS - 1);

   logic [PW-1:0]                head_ff, head_in;
   logic [PW-1:0]                tail_ff, tail_in;
   logic [PW-1:0]                head_nx, tail_nx;
   logic                         wr_en;
   logic                         rd_en;
   logic                         popped;
   logic                         overwrote;
   logic [bdmx_pkg::BYTE_W-1:0]  mem [RING_SLOTS];
   logic [bdmx_pkg::BYTE_W-1:0]  rd_data_ff;

   assign head_nx = (head_ff == LAST) ? '0 : head_ff + PW'(1);
   assign tail_nx = (tail_ff == LAST) ? '0 : tail_ff + PW'(1);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      popped    = 1'b0;
      overwrote = 1'b0;
      if (push) begin
         wr_en   = 1'b1;
         tail_in = tail_nx;
         if (tail_nx == head_ff) begin
            // full: drop the oldest entry
            head_in   = head_nx;
            overwrote = 1'b1;
         end
      end else if (pop && (head_ff != tail_ff)) begin
         rd_en   = 1'b1;
         head_in = head_nx;
         popped  = 1'b1;
      end
   end

   // Wraps modulo 2**PW, which agrees with the slot count for any depth.
   assign count = (tail_in >= head_in) ? tail_in - head_in
                                       : tail_in + PW'(RING_SLOTS) - head_in;

   assign stat.popped    = popped;
   assign stat.overwrote = overwrote;
   assign rd_data        = rd_data_ff;

   // A pop one beat after a push to the same slot sees the write, which
   // lands at the earlier edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= code_in;
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

endmodule

// ----- rtl/packet_and_command_byte_demux.sv -----
// An accepted beat is registered in stage 1, then in the output registers on rsp_.
// Throughput: one beat per cycle while rsp_ready keeps up; each beat makes at most one
// memory write or one read; the packet memory and command ring each register their read.
// Reset clears packet, bank and ring pointers; memory contents are not cleared.
// No clearing pass: the block takes beats as soon as reset is released.
`timescale 1ns / 1ps

module packet_and_command_byte_demux #(
   parameter int PACKET_MAX = 94,
   parameter int RING_SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bdmx_pkg::CMD_W-1:0]          req_cmd,
   input  logic [bdmx_pkg::BYTE_W-1:0]         req_rx_byte,
   input  logic [bdmx_pkg::LEN_W-1:0]          req_read_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_cmd_valid,
   output logic [bdmx_pkg::BYTE_W-1:0]         rsp_cmd_code,
   output logic                                rsp_packet_done,
   output logic [bdmx_pkg::LEN_W-1:0]          rsp_packet_length,
   output logic [bdmx_pkg::BYTE_W-1:0]         rsp_read_data,
   output logic [$clog2(RING_SLOTS)-1:0]       rsp_queue_count,
   output logic                                rsp_queue_overwrote
);

   localparam int CW = $clog2(RING_SLOTS);

   bdmx_pkg::cmd_type            cmd;
   logic                         accept;
   logic                         push;
   logic                         pop;
   bdmx_pkg::pkt_stat_type       pkt_stat;
   bdmx_pkg::ring_stat_type      ring_stat;
   logic [CW-1:0]                ring_count;
   logic [bdmx_pkg::BYTE_W-1:0]  pkt_rd;
   logic [bdmx_pkg::BYTE_W-1:0]  ring_rd;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_adv;
   bdmx_pkg::pkt_stat_type       s1_pkt_ff;
   bdmx_pkg::ring_stat_type      s1_ring_ff;
   logic [CW-1:0]                s1_count_ff;

   logic                         out_valid_ff, out_valid_in;
   logic                         out_cmd_valid_ff;
   logic [bdmx_pkg::BYTE_W-1:0]  out_cmd_code_ff;
   logic                         out_done_ff;
   logic [bdmx_pkg::LEN_W-1:0]   out_length_ff;
   logic [bdmx_pkg::BYTE_W-1:0]  out_data_ff;
   logic [CW-1:0]                out_count_ff;
   logic                         out_over_ff;

   assign cmd    = bdmx_pkg::cmd_type'(req_cmd);
   assign s1_adv = s1_valid_ff && (!out_valid_ff || rsp_ready);

   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   assign push = accept && (cmd == bdmx_pkg::CMD_RX) && !pkt_stat.open
                 && bdmx_pkg::is_cmd_char(req_rx_byte);
   assign pop  = accept && (cmd == bdmx_pkg::CMD_POP);

   bdmx_pkt_asm #(
      .PACKET_MAX (PACKET_MAX)
   ) u_pkt (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (cmd),
      .rx_byte    (req_rx_byte),
      .read_index (req_read_index),
      .stat       (pkt_stat),
      .rd_data    (pkt_rd)
   );

   bdmx_cmd_ring #(
      .RING_SLOTS (RING_SLOTS)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .code_in (req_rx_byte),
      .stat    (ring_stat),
      .count   (ring_count),
      .rd_data (ring_rd)
   );

   // Stage 1 waits on the memory read; the memory data registers hold while
   // it stalls because no new beat is accepted then.
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pkt_ff   <= pkt_stat;
         s1_ring_ff  <= ring_stat;
         s1_count_ff <= ring_count;
      end
      if (s1_adv) begin
         out_cmd_valid_ff <= s1_ring_ff.popped;
         out_cmd_code_ff  <= s1_ring_ff.popped ? ring_rd : '0;
         out_done_ff      <= s1_pkt_ff.done;
         out_length_ff    <= s1_pkt_ff.length;
         out_data_ff      <= s1_pkt_ff.hit ? pkt_rd : '0;
         out_count_ff     <= s1_count_ff;
         out_over_ff      <= s1_ring_ff.overwrote;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_cmd_valid       = out_cmd_valid_ff;
   assign rsp_cmd_code        = out_cmd_code_ff;
   assign rsp_packet_done     = out_done_ff;
   assign rsp_packet_length   = out_length_ff;
   assign rsp_read_data       = out_data_ff;
   assign rsp_queue_count     = out_count_ff;
   assign rsp_queue_overwrote = out_over_ff;

   a_done_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_done |-> !rsp_cmd_valid && (rsp_read_data == '0)
                                       && !rsp_queue_overwrote)
      else $error("packet completion beat carries pop, read or overwrite data");

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_packet_length <= bdmx_pkg::LEN_W'(PACKET_MAX))
      else $error("packet length exceeds packet limit");

   a_overwrite_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_overwrote |-> rsp_queue_count == CW'(RING_SLOTS - 1))
      else $error("overwrite reported with ring not full");

   a_pop_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_valid |-> rsp_cmd_code != '0)
      else $error("popped command code is zero");

   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && !req_ready == !s1_adv)
      else $error("stalled stage dropped its beat");

endmodule

// ----- tb/packet_and_command_byte_demux_tb.sv -----
// Self-checking testbench for the byte demultiplexer: packet assembly, command ring, reads.
`timescale 1ns / 1ps

module packet_and_command_byte_demux_tb;

   localparam int PACKET_MAX       = 94;
   localparam int RING_SLOTS       = 16;
   localparam int CNT_W            = $clog2(RING_SLOTS);
   localparam int CLK_PERIOD       = 12;
   localparam int RESET_CYCLES     = 7;
   localparam int RANDOM_BEATS     = 1425;
   localparam int QUIET_TAIL       = 150;
   localparam int HOLD_AT_BEAT     = 400;
   localparam int PAUSE_AT_BEAT    = 800;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int HOLD_BURST_BEATS = 40;
   localparam int DRAIN_CYCLES     = 10;
   localparam int TIMEOUT_NS       = 5_000_000;

   typedef struct packed {
      logic                       cmd_valid;
      logic [7:0]                 cmd_code;
      logic                       packet_done;
      logic [bdmx_pkg::LEN_W-1:0] packet_length;
      logic [7:0]                 read_data;
      logic [CNT_W-1:0]           queue_count;
      logic                       queue_overwrote;
   } demux_rsp_type;

   typedef struct {
      bdmx_pkg::cmd_type          cmd;
      logic [7:0]                 rx_byte;
      logic [bdmx_pkg::LEN_W-1:0] read_index;
      logic                       has_exp;
      demux_rsp_type              exp;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [bdmx_pkg::CMD_W-1:0]    req_cmd = bdmx_pkg::CMD_IDLE;
   logic [bdmx_pkg::BYTE_W-1:0]   req_rx_byte = '0;
   logic [bdmx_pkg::LEN_W-1:0]    req_read_index = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_cmd_valid;
   logic [bdmx_pkg::BYTE_W-1:0]   rsp_cmd_code;
   logic                          rsp_packet_done;
   logic [bdmx_pkg::LEN_W-1:0]    rsp_packet_length;
   logic [bdmx_pkg::BYTE_W-1:0]   rsp_read_data;
   logic [CNT_W-1:0]              rsp_queue_count;
   logic                          rsp_queue_overwrote;

   // Shadow state of the demultiplexer
   logic                in_pkt = 1'b0;
   int unsigned         fill_pos = 0;
   logic [7:0]          pkt_bank [2][PACKET_MAX];
   logic                done_sel = 1'b0;
   int unsigned         done_len = 0;
   logic [7:0]          cmd_ring [RING_SLOTS];
   logic [CNT_W-1:0]    ring_rd = '0;
   logic [CNT_W-1:0]    ring_wr = '0;

   demux_rsp_type       pending_rsp_q[$];
   demux_rsp_type       oldest_rsp;
   int                  error_count = 0;
   int                  useful_beats = 0;
   logic                counting = 1'b1;
   logic                tx_idle_on = 1'b1;
   logic                rx_idle_on = 1'b1;
   logic                long_hold_req = 1'b0;

   packet_and_command_byte_demux #(
      .PACKET_MAX(PACKET_MAX),
      .RING_SLOTS(RING_SLOTS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_rx_byte        (req_rx_byte),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cmd_valid      (rsp_cmd_valid),
      .rsp_cmd_code       (rsp_cmd_code),
      .rsp_packet_done    (rsp_packet_done),
      .rsp_packet_length  (rsp_packet_length),
      .rsp_read_data      (rsp_read_data),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_queue_overwrote(rsp_queue_overwrote)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic demux_rsp_type mk_res(input logic valid, input logic [7:0] code,
                                            input logic done,
                                            input logic [bdmx_pkg::LEN_W-1:0] len,
                                            input logic [7:0] data, input logic [CNT_W-1:0] cnt,
                                            input logic over);
      demux_rsp_type r;
      r.cmd_valid       = valid;
      r.cmd_code        = code;
      r.packet_done     = done;
      r.packet_length   = len;
      r.read_data       = data;
      r.queue_count     = cnt;
      r.queue_overwrote = over;
      return r;
   endfunction

   function automatic stim_row_type stim_row(input bdmx_pkg::cmd_type c, input logic [7:0] b,
                                             input logic [bdmx_pkg::LEN_W-1:0] ix);
      stim_row_type row;
      row.cmd        = c;
      row.rx_byte    = b;
      row.read_index = ix;
      row.has_exp    = 1'b0;
      row.exp        = '0;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input bdmx_pkg::cmd_type c,
                                                input logic [7:0] b,
                                                input logic [bdmx_pkg::LEN_W-1:0] ix,
                                                input demux_rsp_type want);
      stim_row_type row;
      row         = stim_row(c, b, ix);
      row.has_exp = 1'b1;
      row.exp     = want;
      return row;
   endfunction

   function automatic void store_pkt_byte(input logic [7:0] b);
      if (fill_pos < PACKET_MAX) begin
         pkt_bank[~done_sel][fill_pos] = b;
         fill_pos++;
      end
   endfunction

   // Advance the shadow state by one accepted beat and return its response.
   function automatic demux_rsp_type predict_demux(input bdmx_pkg::cmd_type c,
                                                   input logic [7:0] b,
                                                   input logic [bdmx_pkg::LEN_W-1:0] ix);
      demux_rsp_type r;
      logic [CNT_W-1:0] nxt;
      r = '0;
      case (c)
         bdmx_pkg::CMD_RX: begin
            if (b == bdmx_pkg::CH_DOLLAR) begin
               fill_pos = 0;
               in_pkt   = 1'b1;
               store_pkt_byte(b);
            end else if (in_pkt) begin
               store_pkt_byte(b);
               if (b == bdmx_pkg::CH_NEWLINE) begin
                  done_sel      = ~done_sel;
                  done_len      = fill_pos;
                  in_pkt        = 1'b0;
                  r.packet_done = 1'b1;
               end
            end else if ((b >= bdmx_pkg::CH_UPPER_A && b <= bdmx_pkg::CH_UPPER_Z)
                         || b == bdmx_pkg::CH_QUERY) begin
               nxt = ring_wr + 1'b1;
               // full ring: drop the oldest command
               if (nxt == ring_rd) begin
                  ring_rd           = ring_rd + 1'b1;
                  r.queue_overwrote = 1'b1;
               end
               cmd_ring[ring_wr] = b;
               ring_wr           = nxt;
            end
         end
         bdmx_pkg::CMD_POP: begin
            if (ring_rd != ring_wr) begin
               r.cmd_valid = 1'b1;
               r.cmd_code  = cmd_ring[ring_rd];
               ring_rd     = ring_rd + 1'b1;
            end
         end
         bdmx_pkg::CMD_READ: begin
            if (ix < done_len && ix < PACKET_MAX) r.read_data = pkt_bank[done_sel][ix];
         end
         default: ;
      endcase
      r.packet_length = done_len[bdmx_pkg::LEN_W-1:0];
      r.queue_count   = ring_wr - ring_rd;
      return r;
   endfunction

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == bdmx_pkg::CH_DOLLAR || b == bdmx_pkg::CH_NEWLINE);
      return b;
   endfunction

   function automatic logic [7:0] command_byte();
      if ($urandom_range(0, 26) == 26) return bdmx_pkg::CH_QUERY;
      return bdmx_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
   endfunction

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
         error_count++;
      end
   endtask

   // Offer one beat, hold it until accepted, then record its expected response.
   task automatic send_beat(input stim_row_type row);
      demux_rsp_type pred;
      int unsigned gap;
      gap = 0;
      if (tx_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= row.cmd;
      req_rx_byte    <= row.rx_byte;
      req_read_index <= row.read_index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (counting) useful_beats++;
      pred = predict_demux(row.cmd, row.rx_byte, row.read_index);
      pending_rsp_q.push_back(row.has_exp ? row.exp : pred);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("response beat with nothing outstanding");
            error_count++;
         end else begin
            oldest_rsp = pending_rsp_q.pop_front();
            check_field("cmd_valid", 32'(oldest_rsp.cmd_valid), 32'(rsp_cmd_valid));
            check_field("cmd_code", 32'(oldest_rsp.cmd_code), 32'(rsp_cmd_code));
            check_field("packet_done", 32'(oldest_rsp.packet_done), 32'(rsp_packet_done));
            check_field("packet_length", 32'(oldest_rsp.packet_length),
                        32'(rsp_packet_length));
            check_field("read_data", 32'(oldest_rsp.read_data), 32'(rsp_read_data));
            check_field("queue_count", 32'(oldest_rsp.queue_count), 32'(rsp_queue_count));
            check_field("queue_overwrote", 32'(oldest_rsp.queue_overwrote),
                        32'(rsp_queue_overwrote));
         end
      end
   end

   // Response side: random stall bursts, plus one long hold on request.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("packet_and_command_byte_demux_tb: done, errors");
      $finish;
   end

   initial begin
      stim_row_type   dir_tbl[$];
      int unsigned    sel;
      int unsigned    n;
      int unsigned    body_len;
      int unsigned    rd_top;
      logic [7:0]     b;
      logic           hold_done;
      logic           pause_done;

      hold_done  = 1'b0;
      pause_done = 1'b0;

      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_POP, 8'h00, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd0, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_READ, 8'h00, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd0, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_READ, 8'hFF, 7'd93,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd0, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_IDLE, bdmx_pkg::CH_UPPER_A, 7'd5,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd0, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_RX, bdmx_pkg::CH_NEWLINE, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd0, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_RX, bdmx_pkg::CH_UPPER_A, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd1, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_RX, bdmx_pkg::CH_UPPER_Z, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd2, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_RX, bdmx_pkg::CH_QUERY, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd3, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_RX, 8'h40, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd3, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_RX, 8'h5B, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd3, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_RX, 8'h3E, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd3, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_RX, 8'hFF, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd0, 8'h00, 4'd3, 1'b0)));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_POP, 8'h00, 7'd0,
         mk_res(1'b1, bdmx_pkg::CH_UPPER_A, 1'b0, 7'd0, 8'h00, 4'd2, 1'b0)));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_RX, bdmx_pkg::CH_DOLLAR, 7'd0));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_RX, "Q", 7'd0));
      // dollar inside a packet restarts it
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_RX, bdmx_pkg::CH_DOLLAR, 7'd0));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_RX, 8'h00, 7'd0));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_RX, 8'hFF, 7'd0));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_RX, bdmx_pkg::CH_NEWLINE, 7'd0));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_READ, 8'h00, 7'd0));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_READ, 8'h00, 7'd3));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_READ, 8'h00, 7'd2));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_READ, 8'h00, 7'd4,
         mk_res(1'b0, 8'h00, 1'b0, 7'd4, 8'h00, 4'd2, 1'b0)));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_POP, 8'h00, 7'd0));
      dir_tbl.push_back(stim_row(bdmx_pkg::CMD_POP, 8'h00, 7'd0));
      dir_tbl.push_back(checked_row(bdmx_pkg::CMD_POP, 8'h00, 7'd0,
         mk_res(1'b0, 8'h00, 1'b0, 7'd4, 8'h00, 4'd0, 1'b0)));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tbl[i]) send_beat(dir_tbl[i]);
      useful_beats = 0;

      while (useful_beats < RANDOM_BEATS) begin
         if (!hold_done && useful_beats >= HOLD_AT_BEAT) begin
            // keep offering beats while the response side holds off
            hold_done     = 1'b1;
            tx_idle_on    = 1'b0;
            long_hold_req = 1'b1;
            for (int k = 0; k < HOLD_BURST_BEATS; k++) begin
               if (k[0]) send_beat(stim_row(bdmx_pkg::CMD_POP, 8'h00, 7'd0));
               else send_beat(stim_row(bdmx_pkg::CMD_READ, 8'h00,
                                       7'($urandom_range(0, PACKET_MAX - 1))));
            end
         end
         if (!pause_done && useful_beats >= PAUSE_AT_BEAT) begin
            pause_done = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_rsp_q.size() != 0);
         end

         tx_idle_on = (useful_beats < RANDOM_BEATS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         rx_idle_on = (useful_beats < RANDOM_BEATS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);

         sel = $urandom_range(0, 19);
         if (sel <= 7 || sel >= 18) begin
            // packet: mostly short, sometimes around or past the size limit
            if ($urandom_range(0, 19) == 0) body_len = $urandom_range(PACKET_MAX - 3, 110);
            else body_len = $urandom_range(0, 24);
            send_beat(stim_row(bdmx_pkg::CMD_RX, bdmx_pkg::CH_DOLLAR, 7'd0));
            for (int k = 0; k < body_len; k++) begin
               b = ($urandom_range(0, 99) == 0) ? bdmx_pkg::CH_DOLLAR : body_byte();
               send_beat(stim_row(bdmx_pkg::CMD_RX, b, 7'd0));
            end
            // leave some packets open so following bytes land inside them
            if ($urandom_range(0, 9) != 0) begin
               send_beat(stim_row(bdmx_pkg::CMD_RX, bdmx_pkg::CH_NEWLINE, 7'd0));
               rd_top = (done_len < PACKET_MAX) ? done_len : PACKET_MAX - 1;
               n = $urandom_range(1, 5);
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0)
                     send_beat(stim_row(bdmx_pkg::CMD_READ, 8'h00,
                                        7'($urandom_range(0, PACKET_MAX - 1))));
                  else
                     send_beat(stim_row(bdmx_pkg::CMD_READ, 8'h00,
                                        7'($urandom_range(0, rd_top))));
               end
            end
         end else if (sel <= 11) begin
            n = $urandom_range(1, 20);
            repeat (n) send_beat(stim_row(bdmx_pkg::CMD_RX, command_byte(), 7'd0));
         end else if (sel <= 14) begin
            n = $urandom_range(1, 8);
            repeat (n) send_beat(stim_row(bdmx_pkg::CMD_POP, 8'($urandom_range(0, 255)),
                                          7'd0));
         end else if (sel <= 16) begin
            n = $urandom_range(1, 4);
            repeat (n) send_beat(stim_row(bdmx_pkg::CMD_READ, 8'h00,
                                          7'($urandom_range(0, PACKET_MAX - 1))));
         end else begin
            counting = 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) send_beat(stim_row(bdmx_pkg::cmd_type'(2'($urandom_range(0, 3))),
                                          8'($urandom_range(0, 255)),
                                          7'($urandom_range(0, PACKET_MAX - 1))));
            counting = 1'b1;
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("packet_and_command_byte_demux_tb: done, clean");
      end else begin
         $display("packet_and_command_byte_demux_tb: done, errors");
      end
      $finish;
   end

endmodule
